// File: rtl/core/iff_pkg.sv
// Shared types, codes and the digit character lookup for the integer field formatter.
// The top level and the digit converter both import this package; it has no dependencies.
`timescale 1ns / 1ps

package iff_pkg;

    // Conversion kinds
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_OCT  = 3'd2;
    localparam logic [2:0] KIND_HEX  = 3'd3;
    localparam logic [2:0] KIND_CHAR = 3'd4;

    // Digit count width; holds the digits of any value up to 64 bits
    localparam int LEN_W = 5;

    // ASCII codes used in the field
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    // Control from the top level to the digit converter
    typedef struct packed {
        logic       start;
        logic [2:0] kind;
        logic       shift;
    } t_dig_ctl;

    // Status from the digit converter
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
        logic [3:0]       top;
    } t_dig_stat;

    // One digit value to its lowercase ASCII character
    function automatic logic [7:0] iff_hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'h0, nib};
        end else begin
            ch = CH_LOW_A + {4'h0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// File: rtl/core/iff_digits.sv
// Digit converter: binary magnitude to a register of 4-bit digits, most significant on top.
// Decimal goes by shift-and-add-3, one bit a cycle; then leading zeros are dropped one digit
// a cycle. Depends on iff_pkg.
`timescale 1ns / 1ps

module iff_digits import iff_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dig_ctl              i_ctl,
    input  logic [VALUE_BITS-1:0] i_mag,
    output t_dig_stat             o_stat
);

    localparam int NDIG = (VALUE_BITS + 2) / 3;
    localparam int DW   = 4 * NDIG;
    localparam int CW   = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {D_IDLE, D_DABBLE, D_NORM, D_READY} t_dstate;

    t_dstate                 r_state, n_state;
    logic [DW-1:0]           r_bcd, n_bcd;
    logic [VALUE_BITS-1:0]   r_bin, n_bin;
    logic [CW-1:0]           r_bits, n_bits;
    logic [LEN_W-1:0]        r_len, n_len;

    logic [DW-1:0]           w_pack;
    logic [DW-1:0]           w_oct;
    logic [DW-1:0]           w_adj;

    // Digit fields for octal and hex, and the add-3 correction for decimal
    always_comb begin
        w_pack = DW'(i_mag);
        w_oct  = '0;
        w_adj  = r_bcd;
        for (int i = 0; i < NDIG; i++) begin
            w_oct[4*i +: 4] = {1'b0, w_pack[3*i +: 3]};
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_bin   = r_bin;
        n_bits  = r_bits;
        n_len   = r_len;
        case (r_state)
            D_DABBLE: begin
                n_bcd  = {w_adj[DW-2:0], r_bin[VALUE_BITS-1]};
                n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_bits = r_bits - 1'b1;
                if (r_bits == CW'(1)) begin
                    n_state = D_NORM;
                    n_len   = LEN_W'(NDIG);
                end
            end
            D_NORM: begin
                // drop a leading zero, keep at least one digit
                if (r_len > LEN_W'(1) && r_bcd[DW-1 -: 4] == 4'h0) begin
                    n_bcd = {r_bcd[DW-5:0], 4'h0};
                    n_len = r_len - 1'b1;
                end else begin
                    n_state = D_READY;
                end
            end
            D_READY: begin
                if (i_ctl.shift) begin
                    n_bcd = {r_bcd[DW-5:0], 4'h0};
                end
            end
            default: begin
            end
        endcase
        if (i_ctl.start) begin
            n_len = LEN_W'(NDIG);
            if (i_ctl.kind == KIND_SDEC || i_ctl.kind == KIND_UDEC) begin
                n_bin   = i_mag;
                n_bcd   = '0;
                n_bits  = CW'(VALUE_BITS);
                n_state = D_DABBLE;
            end else begin
                n_bcd   = (i_ctl.kind == KIND_OCT) ? w_oct : w_pack;
                n_state = D_NORM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bcd  <= n_bcd;
        r_bin  <= n_bin;
        r_bits <= n_bits;
        r_len  <= n_len;
    end

    assign o_stat.done = (r_state == D_READY);
    assign o_stat.len  = r_len;
    assign o_stat.top  = r_bcd[DW-1 -: 4];

endmodule

// File: rtl/core/integer_field_formatter_top.sv
// Integer field formatter top level: takes one argument with its field settings and sends
// the formatted field one character per beat. Depends on iff_pkg and iff_digits.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Beat payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | into      | i_valid / o_stall  | kind, value, width, precision, flags
//  out     | out of    | o_valid / i_stall  | character, last
//
//  Decimal kinds run shift-and-add-3, octal and hex skip it; leading zeros are then stripped,
//  S_CONV waits for the digits and S_SETUP sets up the field (a character goes straight to
//  S_SETUP), and one character leaves per cycle unless the output stalls, up to MAX_FIELD.
//  One field is handled at a time; o_stall is high from acceptance until the last character
//  sits in the output register. Reset is synchronous, active low. A stall on the output
//  holds the output register and pauses character generation.

module integer_field_formatter_top import iff_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_width,
    input  logic [5:0]  i_precision,
    input  logic        i_has_precision,
    input  logic        i_left_justify,
    input  logic        i_force_plus,
    input  logic        i_zero_pad,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last
);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_SETUP, S_EMIT} t_state;

    t_state            r_state, n_state;
    logic              r_is_char, n_is_char;
    logic              r_sign_on, n_sign_on;
    logic [7:0]        r_sign_ch, n_sign_ch;
    logic [6:0]        r_width, n_width;
    logic [5:0]        r_prec, n_prec;
    logic              r_hasp, n_hasp;
    logic              r_left, n_left;
    logic              r_zp, n_zp;
    logic [7:0]        r_cnt_a, n_cnt_a;
    logic              r_sign_pend, n_sign_pend;
    logic [7:0]        r_cnt_c, n_cnt_c;
    logic [LEN_W-1:0]  r_cnt_d, n_cnt_d;
    logic [7:0]        r_cnt_e, n_cnt_e;
    logic [6:0]        r_cap, n_cap;
    logic [6:0]        r_emit, n_emit;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;

    logic                  w_in_acc;
    logic [VALUE_BITS-1:0] w_v;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    t_dig_ctl              w_ctl;
    t_dig_stat             w_stat;

    logic                  w_zero_dig;
    logic [5:0]            w_len;
    logic [5:0]            w_min;
    logic [5:0]            w_digits;
    logic [6:0]            w_n;
    logic [6:0]            w_padn;
    logic [5:0]            w_zeros;
    logic                  w_zpe;
    logic [6:0]            w_total;
    logic [6:0]            w_cap;

    logic                  w_step;
    logic                  w_sel_a, w_sel_s, w_sel_c, w_sel_d;
    logic [7:0]            w_ch;

    iff_digits #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag),
        .o_stat  (w_stat)
    );

    // Input side: argument masking and magnitude
    always_comb begin
        w_in_acc = i_valid && (r_state == S_IDLE);
        w_v      = VALUE_BITS'(i_value);
        w_neg    = (i_kind == KIND_SDEC) && w_v[VALUE_BITS-1];
        w_mag    = w_neg ? (~w_v + 1'b1) : w_v;
    end

    // Field layout from the digit count
    always_comb begin
        w_zero_dig = r_hasp && (r_prec == 6'd0) && (w_stat.len == LEN_W'(1))
                     && (w_stat.top == 4'h0);
        w_len      = (r_is_char || w_zero_dig) ? 6'd0 : 6'(w_stat.len);
        w_min      = r_is_char ? 6'd0 : (r_hasp ? r_prec : 6'd1);
        w_digits   = (w_len > w_min) ? w_len : w_min;
        w_n        = 7'(w_digits) + 7'(r_sign_on);
        w_padn     = (r_width > w_n) ? (r_width - w_n) : 7'd0;
        w_zeros    = (w_min > w_len) ? (w_min - w_len) : 6'd0;
        w_zpe      = r_zp && !r_hasp && !r_left && !r_is_char;
        w_total    = w_padn + w_n;
        w_cap      = (w_total > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : w_total;
    end

    // Character selection: lead pad, sign, zeros, digits, trailing pad
    always_comb begin
        w_step  = (r_state == S_EMIT) && (!r_ovalid || !i_stall);
        w_sel_a = (r_cnt_a != 8'd0);
        w_sel_s = !w_sel_a && r_sign_pend;
        w_sel_c = !w_sel_a && !r_sign_pend && (r_cnt_c != 8'd0);
        w_sel_d = !w_sel_a && !r_sign_pend && (r_cnt_c == 8'd0) && (r_cnt_d != '0);
        if (w_sel_s) begin
            w_ch = r_sign_ch;
        end else if (w_sel_c) begin
            w_ch = CH_ZERO;
        end else if (w_sel_d) begin
            w_ch = iff_hex_char(w_stat.top);
        end else begin
            w_ch = CH_SPACE;
        end
        w_ctl.start = w_in_acc && (i_kind == KIND_SDEC || i_kind == KIND_UDEC
                                   || i_kind == KIND_OCT || i_kind == KIND_HEX);
        w_ctl.kind  = i_kind;
        w_ctl.shift = w_step && w_sel_d;
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_is_char   = r_is_char;
        n_sign_on   = r_sign_on;
        n_sign_ch   = r_sign_ch;
        n_width     = r_width;
        n_prec      = r_prec;
        n_hasp      = r_hasp;
        n_left      = r_left;
        n_zp        = r_zp;
        n_cnt_a     = r_cnt_a;
        n_sign_pend = r_sign_pend;
        n_cnt_c     = r_cnt_c;
        n_cnt_d     = r_cnt_d;
        n_cnt_e     = r_cnt_e;
        n_cap       = r_cap;
        n_emit      = r_emit;
        n_ovalid    = r_ovalid;
        n_char      = r_char;
        n_last      = r_last;

        // output register drains when taken
        if (!i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_is_char = (i_kind == KIND_CHAR);
                    n_sign_on = (i_kind == KIND_CHAR) || w_neg || i_force_plus;
                    if (i_kind == KIND_CHAR) begin
                        n_sign_ch = i_value[7:0];
                    end else if (w_neg) begin
                        n_sign_ch = CH_MINUS;
                    end else begin
                        n_sign_ch = CH_PLUS;
                    end
                    n_width = i_width;
                    n_prec  = i_precision;
                    n_hasp  = i_has_precision;
                    n_left  = i_left_justify;
                    n_zp    = i_zero_pad;
                    if (i_kind == KIND_CHAR) begin
                        n_state = S_SETUP;
                    end else if (w_ctl.start) begin
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                if (w_stat.done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_cnt_a     = (!r_left && !w_zpe) ? 8'(w_padn) : 8'd0;
                n_sign_pend = r_sign_on;
                n_cnt_c     = 8'(w_zeros) + (w_zpe ? 8'(w_padn) : 8'd0);
                n_cnt_d     = w_len[LEN_W-1:0];
                n_cnt_e     = r_left ? 8'(w_padn) : 8'd0;
                n_cap       = w_cap;
                n_emit      = 7'd0;
                n_state     = (w_cap == 7'd0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (w_step) begin
                    n_ovalid = 1'b1;
                    n_char   = w_ch;
                    n_last   = (r_emit + 7'd1 == r_cap);
                    n_emit   = r_emit + 7'd1;
                    if (w_sel_a) begin
                        n_cnt_a = r_cnt_a - 8'd1;
                    end else if (w_sel_s) begin
                        n_sign_pend = 1'b0;
                    end else if (w_sel_c) begin
                        n_cnt_c = r_cnt_c - 8'd1;
                    end else if (w_sel_d) begin
                        n_cnt_d = r_cnt_d - 1'b1;
                    end else begin
                        n_cnt_e = r_cnt_e - 8'd1;
                    end
                    if (r_emit + 7'd1 == r_cap) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_is_char   <= n_is_char;
        r_sign_on   <= n_sign_on;
        r_sign_ch   <= n_sign_ch;
        r_width     <= n_width;
        r_prec      <= n_prec;
        r_hasp      <= n_hasp;
        r_left      <= n_left;
        r_zp        <= n_zp;
        r_cnt_a     <= n_cnt_a;
        r_sign_pend <= n_sign_pend;
        r_cnt_c     <= n_cnt_c;
        r_cnt_d     <= n_cnt_d;
        r_cnt_e     <= n_cnt_e;
        r_cap       <= n_cap;
        r_emit      <= n_emit;
        r_char      <= n_char;
        r_last      <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
